// File: sv/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg: shared widths and beat type for the segment intersection unit
// Widths follow from the coordinate width and the fixed-point fraction width.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int CoordBits = 16;
    localparam int FracBits  = 8;

    // Endpoint differences, cross products and their sums
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int NumBits   = ProdBits + 1;

    // Split of the numerator for the two partial products
    localparam int SplitBits = (NumBits + 1) / 2;
    localparam int HiBits    = NumBits - SplitBits;
    localparam int PartBits  = NumBits + CoordBits;

    // Divider: dividend, quotient, final sum
    localparam int RemBits   = PartBits + FracBits;
    localparam int QuotBits  = CoordBits + FracBits;
    localparam int OutBits   = QuotBits;
    localparam int ValBits   = QuotBits + 2;

    // One beat travelling along the divider cells
    typedef struct packed {
        logic [RemBits-1:0]          rem_x;
        logic [RemBits-1:0]          rem_y;
        logic [RemBits-1:0]          dsh;
        logic [QuotBits-1:0]         q_x;
        logic [QuotBits-1:0]         q_y;
        logic                        neg_x;
        logic                        neg_y;
        logic signed [CoordBits-1:0] ax;
        logic signed [CoordBits-1:0] ay;
        logic                        hit;
        logic                        pv;
    } t_div_beat;

endpackage

// File: sv/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front: cross products, sign normalisation and hit test
// Six pipeline stages from endpoints to the dividend of the point division.
// ----------------------------------------------------------------------------
module ssi_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_ax1,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_ay1,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_bx1,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_by1,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_ax2,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_ay2,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_bx2,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_by2,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output ssi_pkg::t_div_beat                   o_beat
);
    import ssi_pkg::*;

    localparam int NStage = 6;

    logic [NStage-1:0] r_v;
    logic [NStage:0]   adv;

    // stage 1: differences
    logic signed [DiffBits-1:0]  r_d1x, r_d1y, r_d2x, r_d2y, r_ex, r_ey;
    logic signed [CoordBits-1:0] r_ax1, r_ay1, r_ax2, r_ay2, r_ax3, r_ay3;
    logic signed [CoordBits-1:0] r_ax4, r_ay4, r_ax5, r_ay5;
    logic                        r_id1, r_id2, r_id3, r_id4;
    // stage 2: products
    logic signed [ProdBits-1:0]  r_pa1, r_pa2, r_pb1, r_pb2, r_pd1, r_pd2;
    logic signed [DiffBits-1:0]  r_d1x2, r_d1y2, r_d1x3, r_d1y3;
    // stage 3: sums
    logic signed [NumBits-1:0]   r_na3, r_nb3, r_den3;
    // stage 4: normalised
    logic signed [NumBits-1:0]   r_na4, r_nb4, r_den4;
    logic [CoordBits-1:0]        r_absx4, r_absy4;
    logic                        r_negx4, r_negy4;
    // stage 5: partial products and hit
    logic [SplitBits+CoordBits-1:0] r_lox, r_loy;
    logic [HiBits+CoordBits-1:0]    r_hix, r_hiy;
    logic [NumBits-1:0]             r_den5;
    logic                           r_negx5, r_negy5, r_hit5, r_pv5;
    // stage 6: dividend
    ssi_pkg::t_div_beat             r_beat;

    logic signed [DiffBits-1:0] n_absx, n_absy;
    logic                       n_neg, n_in;
    logic [PartBits-1:0]        n_px, n_py;

    // Let each stage move when empty or when its successor moves
    always_comb begin
        adv[NStage] = i_ready;
        for (int k = NStage - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NStage-1];
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NStage; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: form direction and offset vectors
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d1x <= DiffBits'(i_bx1) - DiffBits'(i_ax1);
            r_d1y <= DiffBits'(i_by1) - DiffBits'(i_ay1);
            r_d2x <= DiffBits'(i_bx2) - DiffBits'(i_ax2);
            r_d2y <= DiffBits'(i_by2) - DiffBits'(i_ay2);
            r_ex  <= DiffBits'(i_ax1) - DiffBits'(i_ax2);
            r_ey  <= DiffBits'(i_ay1) - DiffBits'(i_ay2);
            r_ax1 <= i_ax1;
            r_ay1 <= i_ay1;
            r_id1 <= (i_ax1 == i_ax2) && (i_ay1 == i_ay2)
                     && (i_bx1 == i_bx2) && (i_by1 == i_by2);
        end
    end

    // Stage 2: six cross-product terms
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_pa1  <= r_d2x * r_ey;
            r_pa2  <= r_d2y * r_ex;
            r_pb1  <= r_d1x * r_ey;
            r_pb2  <= r_d1y * r_ex;
            r_pd1  <= r_d2y * r_d1x;
            r_pd2  <= r_d2x * r_d1y;
            r_d1x2 <= r_d1x;
            r_d1y2 <= r_d1y;
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_id2  <= r_id1;
        end
    end

    // Stage 3: numerators and denominator
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_na3  <= NumBits'(r_pa1) - NumBits'(r_pa2);
            r_nb3  <= NumBits'(r_pb1) - NumBits'(r_pb2);
            r_den3 <= NumBits'(r_pd1) - NumBits'(r_pd2);
            r_d1x3 <= r_d1x2;
            r_d1y3 <= r_d1y2;
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_id3  <= r_id2;
        end
    end

    // Stage 4: flip signs so the denominator is not negative
    always_comb begin
        n_neg  = r_den3[NumBits-1];
        n_absx = r_d1x3[DiffBits-1] ? -r_d1x3 : r_d1x3;
        n_absy = r_d1y3[DiffBits-1] ? -r_d1y3 : r_d1y3;
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_na4   <= n_neg ? -r_na3 : r_na3;
            r_nb4   <= n_neg ? -r_nb3 : r_nb3;
            r_den4  <= n_neg ? -r_den3 : r_den3;
            r_absx4 <= n_absx[CoordBits-1:0];
            r_absy4 <= n_absy[CoordBits-1:0];
            r_negx4 <= r_d1x3[DiffBits-1];
            r_negy4 <= r_d1y3[DiffBits-1];
            r_ax4   <= r_ax3;
            r_ay4   <= r_ay3;
            r_id4   <= r_id3;
        end
    end

    // Stage 5: range test, split products numA * |d1|
    assign n_in = (r_den4 > 0) && (r_na4 >= 0) && (r_na4 <= r_den4)
                  && (r_nb4 >= 0) && (r_nb4 <= r_den4);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_lox   <= r_na4[SplitBits-1:0] * r_absx4;
            r_loy   <= r_na4[SplitBits-1:0] * r_absy4;
            r_hix   <= r_na4[NumBits-1:SplitBits] * r_absx4;
            r_hiy   <= r_na4[NumBits-1:SplitBits] * r_absy4;
            r_den5  <= r_den4;
            r_negx5 <= r_negx4;
            r_negy5 <= r_negy4;
            r_hit5  <= r_id4 || n_in;
            r_pv5   <= !r_id4 && n_in;
            r_ax5   <= r_ax4;
            r_ay5   <= r_ay4;
        end
    end

    // Stage 6: join partials, scale dividend, align divisor to the top bit
    assign n_px = PartBits'(r_lox) + (PartBits'(r_hix) << SplitBits);
    assign n_py = PartBits'(r_loy) + (PartBits'(r_hiy) << SplitBits);

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_beat.rem_x <= RemBits'(n_px) << FracBits;
            r_beat.rem_y <= RemBits'(n_py) << FracBits;
            r_beat.dsh   <= RemBits'(r_den5) << (QuotBits - 1);
            r_beat.q_x   <= '0;
            r_beat.q_y   <= '0;
            r_beat.neg_x <= r_negx5;
            r_beat.neg_y <= r_negy5;
            r_beat.ax    <= r_ax5;
            r_beat.ay    <= r_ay5;
            r_beat.hit   <= r_hit5;
            r_beat.pv    <= r_pv5;
        end
    end

endmodule

// File: sv/ssi_div_cell.sv
// ----------------------------------------------------------------------------
// ssi_div_cell: one restoring-division step for x and y
// Produces one quotient bit per coordinate and halves the aligned divisor.
// ----------------------------------------------------------------------------
module ssi_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ssi_pkg::t_div_beat i_beat,
    output logic               o_valid,
    input  logic               i_ready,
    output ssi_pkg::t_div_beat o_beat
);
    import ssi_pkg::*;

    logic      r_valid;
    t_div_beat r_beat;
    t_div_beat n_beat;
    logic      adv, ge_x, ge_y;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // Subtract where the divisor fits, shift in the quotient bit
    always_comb begin
        n_beat       = i_beat;
        ge_x         = i_beat.rem_x >= i_beat.dsh;
        ge_y         = i_beat.rem_y >= i_beat.dsh;
        n_beat.rem_x = ge_x ? i_beat.rem_x - i_beat.dsh : i_beat.rem_x;
        n_beat.rem_y = ge_y ? i_beat.rem_y - i_beat.dsh : i_beat.rem_y;
        n_beat.q_x   = {i_beat.q_x[QuotBits-2:0], ge_x};
        n_beat.q_y   = {i_beat.q_y[QuotBits-2:0], ge_y};
        n_beat.dsh   = i_beat.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_beat <= n_beat;
        end
    end

endmodule

// File: sv/ssi_fixup.sv
// ----------------------------------------------------------------------------
// ssi_fixup: signed rounding toward zero and output register
// Turns the unsigned quotient into the Q-format point and holds the result.
// ----------------------------------------------------------------------------
module ssi_fixup (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  ssi_pkg::t_div_beat                    i_beat,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_hit,
    output logic                                  o_point_valid,
    output logic signed [ssi_pkg::OutBits-1:0]    o_cross_x,
    output logic signed [ssi_pkg::OutBits-1:0]    o_cross_y
);
    import ssi_pkg::*;

    logic                     r_valid, r_hit, r_pv;
    logic signed [OutBits-1:0] r_cx, r_cy;
    logic                     adv, nz_x, nz_y;
    logic signed [ValBits-1:0] n_qx, n_qy, n_vx, n_vy, n_bx, n_by;

    assign adv           = !r_valid || i_ready;
    assign o_ready       = adv;
    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_point_valid = r_pv;
    assign o_cross_x     = r_cx;
    assign o_cross_y     = r_cy;

    // Floor of the signed offset, then step up once for a negative inexact sum
    always_comb begin
        nz_x = i_beat.rem_x != '0;
        nz_y = i_beat.rem_y != '0;
        n_qx = ValBits'(i_beat.q_x) + ValBits'(nz_x);
        n_qy = ValBits'(i_beat.q_y) + ValBits'(nz_y);
        if (i_beat.neg_x) begin
            n_qx = -n_qx;
        end else begin
            n_qx = ValBits'(i_beat.q_x);
        end
        if (i_beat.neg_y) begin
            n_qy = -n_qy;
        end else begin
            n_qy = ValBits'(i_beat.q_y);
        end
        n_bx = (ValBits'(i_beat.ax) <<< FracBits) + n_qx;
        n_by = (ValBits'(i_beat.ay) <<< FracBits) + n_qy;
        n_vx = (n_bx[ValBits-1] && nz_x) ? n_bx + ValBits'(1) : n_bx;
        n_vy = (n_by[ValBits-1] && nz_y) ? n_by + ValBits'(1) : n_by;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    // Hold the result until the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= i_beat.hit;
            r_pv  <= i_beat.pv;
            r_cx  <= i_beat.pv ? n_vx[OutBits-1:0] : '0;
            r_cy  <= i_beat.pv ? n_vy[OutBits-1:0] : '0;
        end
    end

endmodule

// File: sv/segment_segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection_unit: 2D segment-segment intersection test
// Input channel: one beat carries both segments' endpoints (i_valid/o_ready).
// Output channel: one beat per input with hit, point_valid and the point in
// signed Q16.8, truncated toward zero (o_valid/i_ready).
// Throughput: one beat per cycle while the receiver does not stall. A beat
// passes 6 front stages, 24 divider cells and 1 output register; the first
// stage loads at the accepting edge, and each cell resolves one quotient bit.
// Identical segments report a hit with no point; parallel or degenerate
// pairs report no hit. Points are zero whenever point_valid is low.
// Reset (i_rst_n low at a clock edge) empties every stage; no beat is lost
// or repeated afterwards. When the receiver stalls, each stage holds its
// beat and empty stages still fill, so o_ready drops only once the whole
// pipeline is full.
// ----------------------------------------------------------------------------
module segment_segment_intersection_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_first_ax,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_first_ay,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_first_bx,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_first_by,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_second_ax,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_second_ay,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_second_bx,
    input  logic signed [ssi_pkg::CoordBits-1:0] i_second_by,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit,
    output logic                                 o_point_valid,
    output logic signed [ssi_pkg::OutBits-1:0]   o_cross_x,
    output logic signed [ssi_pkg::OutBits-1:0]   o_cross_y
);
    import ssi_pkg::*;

    t_div_beat           chain_beat  [QuotBits+1];
    logic [QuotBits:0]   chain_valid;
    logic [QuotBits:0]   chain_ready;

    // Front: products, normalisation, range test
    ssi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ax1   (i_first_ax),
        .i_ay1   (i_first_ay),
        .i_bx1   (i_first_bx),
        .i_by1   (i_first_by),
        .i_ax2   (i_second_ax),
        .i_ay2   (i_second_ay),
        .i_bx2   (i_second_bx),
        .i_by2   (i_second_by),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_beat  (chain_beat[0])
    );

    // Row of division cells, one quotient bit each
    for (genvar g = 0; g < QuotBits; g++) begin : g_cell
        ssi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_beat  (chain_beat[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_beat  (chain_beat[g+1])
        );
    end

    // Sign fix-up and output register
    ssi_fixup u_fixup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (chain_valid[QuotBits]),
        .o_ready       (chain_ready[QuotBits]),
        .i_beat        (chain_beat[QuotBits]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_point_valid (o_point_valid),
        .o_cross_x     (o_cross_x),
        .o_cross_y     (o_cross_y)
    );

`ifndef NO_ASSERTIONS
    // A point is only ever reported together with a hit
    a_pv_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_valid |-> o_hit)
        else $error("point reported without hit");

    // Without a point the coordinates read as zero
    a_zero_pt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> (o_cross_x == '0) && (o_cross_y == '0))
        else $error("coordinates set without a point");

    // Reset leaves the output side empty
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    // An accepting receiver keeps the fix-up stage ready, whether full or not
    a_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> chain_ready[QuotBits])
        else $error("fix-up stage stalled while receiver ready");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: segment intersection unit, self-checking
// Random and directed segment pairs are driven through a valid/ready input;
// each output beat is checked against an exact integer prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int CB = ssi_pkg::CoordBits;
    localparam int FB = ssi_pkg::FracBits;
    localparam int OB = ssi_pkg::OutBits;
    localparam longint CycleLimit = 400000;
    localparam logic signed [CB-1:0] MX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] MN = {1'b1, {(CB-1){1'b0}}};

    typedef struct packed {
        logic signed [CB-1:0] fax, fay, fbx, fby, sax, say, sbx, sby;
    } t_pair;

    typedef struct packed {
        logic          hit;
        logic          pv;
        logic [OB-1:0] cx;
        logic [OB-1:0] cy;
    } t_isect;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_hit, o_point_valid;
    logic signed [OB-1:0] o_cross_x, o_cross_y;
    t_pair drive_pair = '0;

    t_pair  pending_pairs[$];
    t_isect expected_isects[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     stim_done = 1'b0;
    bit     accepted_last = 1'b0;
    int     mismatches = 0;
    longint cycles = 0;

    segment_segment_intersection_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_first_ax(drive_pair.fax), .i_first_ay(drive_pair.fay),
        .i_first_bx(drive_pair.fbx), .i_first_by(drive_pair.fby),
        .i_second_ax(drive_pair.sax), .i_second_ay(drive_pair.say),
        .i_second_bx(drive_pair.sbx), .i_second_by(drive_pair.sby),
        .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit),
        .o_point_valid(o_point_valid), .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    always #4 i_clk = ~i_clk;

    // trunc((base*den + prod) * 2^FB / den) with den > 0
    function automatic longint fixed_coord(longint base, longint prod, longint den);
        longint n, q, r;
        n = base * den + prod;
        q = n / den;
        r = n % den;
        return q * (longint'(1) << FB) + (r * (longint'(1) << FB)) / den;
    endfunction

    function automatic t_isect predict_isect(t_pair p);
        t_isect res;
        longint d1x, d1y, d2x, d2y, ex, ey, na, nb, den;
        res = '0;
        if (p.fax == p.sax && p.fay == p.say && p.fbx == p.sbx && p.fby == p.sby) begin
            res.hit = 1'b1;
        end else begin
            d1x = longint'(p.fbx) - p.fax;  d1y = longint'(p.fby) - p.fay;
            d2x = longint'(p.sbx) - p.sax;  d2y = longint'(p.sby) - p.say;
            ex  = longint'(p.fax) - p.sax;  ey  = longint'(p.fay) - p.say;
            na  = d2x * ey - d2y * ex;
            nb  = d1x * ey - d1y * ex;
            den = d2y * d1x - d2x * d1y;
            if (den < 0) begin
                den = -den; na = -na; nb = -nb;
            end
            if (den > 0 && na >= 0 && na <= den && nb >= 0 && nb <= den) begin
                res.hit = 1'b1;
                res.pv  = 1'b1;
                res.cx  = OB'(fixed_coord(p.fax, na * d1x, den));
                res.cy  = OB'(fixed_coord(p.fay, na * d1y, den));
            end
        end
        return res;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(int span);
        if (span == 0) return CB'($urandom);
        return CB'($urandom_range(2 * span) - span);
    endfunction

    // Build a pair that crosses often: second segment spans the first one
    function automatic t_pair crossing_pair(int span);
        t_pair p;
        p.fax = rand_coord(span); p.fay = rand_coord(span);
        p.fbx = rand_coord(span); p.fby = rand_coord(span);
        p.sax = rand_coord(span); p.say = rand_coord(span);
        p.sbx = (p.fax + p.fbx) - p.sax;
        p.sby = (p.fay + p.fby) - p.say;
        return p;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int    kind;
        int    span;
        kind = $urandom_range(9);
        span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(2, 14));
        if (kind < 5) begin
            p = crossing_pair(span);
        end else begin
            p = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                 rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
            // copy or parallel shapes
            if (kind == 7) {p.sax, p.say, p.sbx, p.sby} = {p.fax, p.fay, p.fbx, p.fby};
            if (kind == 8) {p.sax, p.say, p.sbx, p.sby} = {p.fbx, p.fby, p.fax, p.fay};
            if (kind == 9) begin
                p.sbx = p.sax + (p.fbx - p.fax);
                p.sby = p.say + (p.fby - p.fay);
            end
        end
        return p;
    endfunction

    // Wait until nothing is queued, offered or in flight
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_isects.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Stimulus and phase control
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes, identical, reversed, parallel, degenerate, endpoint touch
        pending_pairs.push_back({MN, MN, MX, MX, MN, MX, MX, MN});
        pending_pairs.push_back({MX, MN, MN, MX, MN, MN, MX, MX});
        pending_pairs.push_back({MN, MN, MX, MX, MN, MN, MX, MX});
        pending_pairs.push_back({MN, MN, MX, MX, MX, MX, MN, MN});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0,
                                 16'sd0, 16'sd5, 16'sd10, 16'sd5});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0,
                                 16'sd5, 16'sd0, 16'sd20, 16'sd0});
        pending_pairs.push_back({16'sd3, 16'sd3, 16'sd3, 16'sd3,
                                 16'sd0, 16'sd0, 16'sd9, 16'sd9});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd10,
                                 16'sd10, 16'sd10, 16'sd20, 16'sd0});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd3, 16'sd0,
                                 16'sd1, -16'sd1, 16'sd1, 16'sd2});
        pending_pairs.push_back({-16'sd7, -16'sd1, 16'sd2, 16'sd4,
                                 -16'sd5, 16'sd3, 16'sd1, -16'sd6});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd0,
                                 16'sd5, -16'sd1, 16'sd5, 16'sd1});
        pending_pairs.push_back({MX, MX, MN, MN, MX, MN, MN, MX});
        pending_pairs.push_back({16'sd0, MN, 16'sd0, MX, MN, 16'sd0, MX, -16'sd1});
        pending_pairs.push_back('1);
        pending_pairs.push_back('0);

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 37 : 0;
            recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 37 : 0;
            repeat (385) pending_pairs.push_back(random_pair());
            wait_drained();
        end
        stim_done = 1'b1;
    end

    // Driver: hold the beat until accepted
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || accepted_last) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_pair <= pending_pairs.pop_front();
                    i_valid    <= 1'b1;
                end else begin
                    i_valid    <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Acceptance seen at the rising edge, consumed by the driver
    always @(posedge i_clk) begin
        accepted_last <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            expected_isects.push_back(predict_isect(drive_pair));
    end

    // Monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        t_isect got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_hit, o_point_valid, o_cross_x, o_cross_y};
            if (expected_isects.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: hit=%0b pv=%0b x=%h y=%h",
                             got.hit, got.pv, got.cx, got.cy);
            end else begin
                want = expected_isects.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp hit=%0b pv=%0b x=%h y=%h",
                                  " got hit=%0b pv=%0b x=%h y=%h"},
                                 want.hit, want.pv, want.cx, want.cy,
                                 got.hit, got.pv, got.cx, got.cy);
                end
            end
        end
    end

    // End of run and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("segment_segment_intersection_unit verification failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_isects.size() == 0) begin
            $display("segment_segment_intersection_unit verification clean");
        end else begin
            $display("segment_segment_intersection_unit verification failed");
        end
        $finish;
    end

endmodule
